@@ rtl/core/rect_fill_draw_device_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle fill draw device
// Concurrent check helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RECT_FILL_DRAW_DEVICE_MACROS_SVH
`define RECT_FILL_DRAW_DEVICE_MACROS_SVH

`ifndef SYNTHESIS
// check that cons holds in the same cycle as ante
`define RFD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfd: same-cycle check failed");
// check that cons holds in the cycle after ante
`define RFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfd: next-cycle check failed");
`else
`define RFD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define RFD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/rfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Rectangle fill draw device package
// Port codes, draw codes, operation codes and the queue word type.
// ----------------------------------------------------------------------------
package rfd_pkg;

   // device ports
   localparam logic [7:0] PORT_X     = 8'h20;
   localparam logic [7:0] PORT_Y     = 8'h21;
   localparam logic [7:0] PORT_W     = 8'h22;
   localparam logic [7:0] PORT_H     = 8'h23;
   localparam logic [7:0] PORT_COLOR = 8'h24;
   localparam logic [7:0] PORT_DRAW  = 8'h25;

   // draw port values
   localparam logic [7:0] DRAW_NOP    = 8'd0;
   localparam logic [7:0] DRAW_SCREEN = 8'd1;
   localparam logic [7:0] DRAW_RECT   = 8'd2;

   // number of valid color indices
   localparam logic [7:0] COLOR_COUNT = 8'd2;

   // input commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // configuration register indices
   localparam logic CFG_BACKGROUND = 1'b0;
   localparam logic CFG_INK        = 1'b1;

   // configuration reset values
   localparam logic [31:0] BACKGROUND_RESET = 32'hfff4f1e9;
   localparam logic [31:0] INK_RESET        = 32'hffdc5c36;

   // back-end operations
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_FILL = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // one classified word passed from front to back
   typedef struct packed {
      logic [1:0]  op;
      logic        color;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  w;
      logic [7:0]  h;
      logic [11:0] pixel_index;
      logic        fault;
      logic [31:0] frames;
      logic        handed;
   } entry_type;

endpackage

@@ rtl/core/rfd_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command word into the device.
// ----------------------------------------------------------------------------
interface rfd_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  port;
   logic [7:0]  value;
   logic [11:0] pixel_index;

   modport source (output valid, output command, output port, output value,
                   output pixel_index, input ready);
   modport sink   (input valid, input command, input port, input value,
                   input pixel_index, output ready);
endinterface

@@ rtl/core/rfd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word out of the device.
// ----------------------------------------------------------------------------
interface rfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        fault;
   logic [31:0] frame_count;
   logic        handed_on;
   logic [31:0] pixel_color;

   modport source (output valid, output fault, output frame_count,
                   output handed_on, output pixel_color, input ready);
   modport sink   (input valid, input fault, input frame_count,
                   input handed_on, input pixel_color, output ready);
endinterface

@@ rtl/core/rect_fill_draw_device.sv @@
// ----------------------------------------------------------------------------
// Rectangle fill draw device
// Byte-port drawing device with a one-bit-per-pixel framebuffer.
// Words enter on req_bus: command 0 writes value to port (0x20..0x24 set
// x, y, width, height and color index, 0x25 draws), command 1 reads the
// pixel at pixel_index. Every word gives exactly one word on rsp_bus with
// the fault flag, frame count, handed_on and the pixel's ARGB color.
// The palette sits on the csr_ write port (index 0 background, 1 ink).
// Fills sweep the rectangle through the framebuffer write port at one
// pixel a cycle; a full-screen fill sweeps all SCREEN_WIDTH by
// SCREEN_HEIGHT pixels. A two-word queue lets the front accept words
// while the back is filling or its result waits on a stalled receiver;
// once the queue is full req_bus.ready drops until the back pops the
// next word. After reset the back sweeps the framebuffer to background;
// req_bus.ready stays low until that sweep ends.
// ----------------------------------------------------------------------------
`include "rect_fill_draw_device_macros.svh"

module rect_fill_draw_device #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   rfd_req_if.sink     req_bus,
   rfd_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   rfd_pkg::entry_type push_data;
   rfd_pkg::entry_type pop_data;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   logic               clearing;

   rfd_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .clearing (clearing),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (push_data)
   );

   rfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   rfd_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_bus   (rsp_bus)
   );

   // no word is taken while the framebuffer is being cleared
   `RFD_ASSERT_SAME(a_no_accept_clear, clock, reset, clearing, !req_bus.ready)
   // the queue stays empty through the clearing sweep
   `RFD_ASSERT_SAME(a_queue_empty_clear, clock, reset, clearing, q_empty)
   // never push into a full queue
   `RFD_ASSERT_SAME(a_no_overflow, clock, reset, q_push, !q_full)
   // a pop drains an entry that was pushed earlier
   `RFD_ASSERT_SAME(a_no_underflow, clock, reset, q_pop, !q_empty)

endmodule

@@ rtl/core/rfd_queue.sv @@
// ----------------------------------------------------------------------------
// Front-to-back queue
// Two-entry FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module rfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rfd_pkg::entry_type push_data,
   input  logic               pop,
   output rfd_pkg::entry_type pop_data,
   output logic               full,
   output logic               empty
);

   localparam int DEPTH = 2;

   rfd_pkg::entry_type slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/rfd_front.sv @@
// ----------------------------------------------------------------------------
// Front end
// Accepts request words, keeps parameter bytes, fault and frame count,
// and classifies each word into a back-end operation.
// ----------------------------------------------------------------------------
module rfd_front #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   rfd_req_if.sink            req_bus,
   input  logic               clearing,
   input  logic               q_full,
   output logic               q_push,
   output rfd_pkg::entry_type q_data
);

   localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;

   logic [7:0]  rect_x_ff, rect_x_in;
   logic [7:0]  rect_y_ff, rect_y_in;
   logic [7:0]  rect_w_ff, rect_w_in;
   logic [7:0]  rect_h_ff, rect_h_in;
   logic [7:0]  color_ff, color_in;
   logic        fault_ff, fault_in;
   logic [31:0] frames_ff, frames_in;
   logic        accept;
   logic        out_of_bounds;
   logic        in_range;

   assign req_bus.ready = !q_full && !clearing;
   assign accept        = req_bus.valid && req_bus.ready;
   assign q_push        = accept;

   assign out_of_bounds = ((9'(rect_x_ff) + 9'(rect_w_ff)) > 9'(SCREEN_WIDTH))
                       || ((9'(rect_y_ff) + 9'(rect_h_ff)) > 9'(SCREEN_HEIGHT))
                       || (rect_w_ff == 8'd0) || (rect_h_ff == 8'd0);
   assign in_range      = 17'(req_bus.pixel_index) < 17'(PIX);

   // classify the word and work out the next register values
   always_comb begin
      rect_x_in = rect_x_ff;
      rect_y_in = rect_y_ff;
      rect_w_in = rect_w_ff;
      rect_h_in = rect_h_ff;
      color_in  = color_ff;
      fault_in  = fault_ff;
      frames_in = frames_ff;

      q_data             = '0;
      q_data.op          = rfd_pkg::OP_NONE;
      q_data.color       = color_ff[0];
      q_data.x           = rect_x_ff;
      q_data.y           = rect_y_ff;
      q_data.w           = rect_w_ff;
      q_data.h           = rect_h_ff;
      q_data.pixel_index = req_bus.pixel_index;

      if (req_bus.command == rfd_pkg::CMD_WRITE) begin
         q_data.handed = 1'b1;
         unique case (req_bus.port)
            rfd_pkg::PORT_X:     rect_x_in = req_bus.value;
            rfd_pkg::PORT_Y:     rect_y_in = req_bus.value;
            rfd_pkg::PORT_W:     rect_w_in = req_bus.value;
            rfd_pkg::PORT_H:     rect_h_in = req_bus.value;
            rfd_pkg::PORT_COLOR: color_in  = req_bus.value;
            rfd_pkg::PORT_DRAW: begin
               q_data.handed = 1'b0;
               // drop draws of value zero and draws while faulted
               priority if (req_bus.value == rfd_pkg::DRAW_NOP || fault_ff) begin
                  fault_in = fault_ff;
               end else if (color_ff >= rfd_pkg::COLOR_COUNT) begin
                  fault_in = 1'b1;
               end else if (req_bus.value == rfd_pkg::DRAW_SCREEN) begin
                  q_data.op = rfd_pkg::OP_FILL;
                  q_data.x  = 8'd0;
                  q_data.y  = 8'd0;
                  q_data.w  = 8'(SCREEN_WIDTH);
                  q_data.h  = 8'(SCREEN_HEIGHT);
               end else if (req_bus.value == rfd_pkg::DRAW_RECT) begin
                  if (out_of_bounds) begin
                     fault_in = 1'b1;
                  end else begin
                     q_data.op = rfd_pkg::OP_FILL;
                     frames_in = frames_ff + 32'd1;
                  end
               end else begin
                  fault_in = 1'b1;
               end
            end
            default: q_data.handed = 1'b1;
         endcase
      end else if (in_range) begin
         q_data.op = rfd_pkg::OP_READ;
      end

      q_data.fault  = fault_in;
      q_data.frames = frames_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff <= 8'd0;
         rect_y_ff <= 8'd0;
         rect_w_ff <= 8'd0;
         rect_h_ff <= 8'd0;
         color_ff  <= 8'd0;
         fault_ff  <= 1'b0;
         frames_ff <= 32'd0;
      end else if (accept) begin
         rect_x_ff <= rect_x_in;
         rect_y_ff <= rect_y_in;
         rect_w_ff <= rect_w_in;
         rect_h_ff <= rect_h_in;
         color_ff  <= color_in;
         fault_ff  <= fault_in;
         frames_ff <= frames_in;
      end
   end

endmodule

@@ rtl/core/rfd_back.sv @@
// ----------------------------------------------------------------------------
// Back end
// Owns the framebuffer and palette, sweeps fills one pixel a cycle,
// reads pixels back and holds the result word for the response channel.
// ----------------------------------------------------------------------------
module rfd_back #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               q_empty,
   input  rfd_pkg::entry_type q_data,
   output logic               q_pop,
   output logic               clearing,
   rfd_rsp_if.source          rsp_bus
);

   localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_FILL  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // word that drives the clearing sweep after reset
   localparam rfd_pkg::entry_type CLEAR_WORD = '{
      op: rfd_pkg::OP_NONE, color: 1'b0, x: 8'd0, y: 8'd0,
      w: 8'(SCREEN_WIDTH), h: 8'(SCREEN_HEIGHT), pixel_index: 12'd0,
      fault: 1'b0, frames: 32'd0, handed: 1'b0
   };

   logic [1:0]         state_ff, state_in;
   logic               clear_ff, clear_in;
   rfd_pkg::entry_type cur_ff, cur_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [7:0]         col_ff, col_in;
   logic [7:0]         rows_ff, rows_in;
   logic               rd_bit_ff;
   logic [31:0]        bg_ff;
   logic [31:0]        ink_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_fault_ff, rsp_fault_in;
   logic [31:0]        rsp_frames_ff, rsp_frames_in;
   logic               rsp_handed_ff, rsp_handed_in;
   logic [31:0]        rsp_color_ff, rsp_color_in;

   logic               fb_mem [PIX];
   logic               slot_free;
   logic               last_col;
   logic               last_row;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [15:0]        row_base;

   assign clearing  = clear_ff;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign last_col  = (9'(col_ff) + 9'd1) == (9'(cur_ff.x) + 9'(cur_ff.w));
   assign last_row  = (rows_ff == 8'd1);
   assign row_base  = 16'(cur_ff.y) * 16'(SCREEN_WIDTH);

   assign wr_en   = (state_ff == ST_FILL);
   assign wr_addr = base_ff + AW'(col_ff);
   assign rd_en   = q_pop && (q_data.op == rfd_pkg::OP_READ);
   assign rd_addr = AW'(q_data.pixel_index);

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.fault       = rsp_fault_ff;
   assign rsp_bus.frame_count = rsp_frames_ff;
   assign rsp_bus.handed_on   = rsp_handed_ff;
   assign rsp_bus.pixel_color = rsp_color_ff;

   // sequence fills, reads and result hand-off
   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      cur_in        = cur_ff;
      base_in       = base_ff;
      col_in        = col_ff;
      rows_in       = rows_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_fault_in  = rsp_fault_ff;
      rsp_frames_in = rsp_frames_ff;
      rsp_handed_in = rsp_handed_ff;
      rsp_color_in  = rsp_color_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               cur_in   = q_data;
               state_in = (q_data.op == rfd_pkg::OP_FILL) ? ST_SETUP : ST_DONE;
            end
         end
         ST_SETUP: begin
            base_in  = row_base[AW-1:0];
            col_in   = cur_ff.x;
            rows_in  = cur_ff.h;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            if (last_col) begin
               col_in  = cur_ff.x;
               base_in = base_ff + AW'(SCREEN_WIDTH);
               rows_in = rows_ff - 8'd1;
               if (last_row) begin
                  clear_in = 1'b0;
                  state_in = clear_ff ? ST_IDLE : ST_DONE;
               end
            end else begin
               col_in = col_ff + 8'd1;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fault_in  = cur_ff.fault;
               rsp_frames_in = cur_ff.frames;
               rsp_handed_in = cur_ff.handed;
               if (cur_ff.op == rfd_pkg::OP_READ) begin
                  rsp_color_in = rd_bit_ff ? ink_ff : bg_ff;
               end else begin
                  rsp_color_in = 32'd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // start the clearing sweep over the whole screen
         state_ff     <= ST_SETUP;
         clear_ff     <= 1'b1;
         cur_ff       <= CLEAR_WORD;
         base_ff      <= '0;
         col_ff       <= 8'd0;
         rows_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         cur_ff       <= cur_in;
         base_ff      <= base_in;
         col_ff       <= col_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result payload
   always_ff @(posedge clock) begin
      rsp_fault_ff  <= rsp_fault_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_handed_ff <= rsp_handed_in;
      rsp_color_ff  <= rsp_color_in;
   end

   // palette registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff  <= rfd_pkg::BACKGROUND_RESET;
         ink_ff <= rfd_pkg::INK_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == rfd_pkg::CFG_BACKGROUND) begin
            bg_ff <= csr_wdata;
         end
         if (csr_index == rfd_pkg::CFG_INK) begin
            ink_ff <= csr_wdata;
         end
      end
   end

   // framebuffer: one write port for fills, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fb_mem[wr_addr] <= cur_ff.color;
      end
      if (rd_en) begin
         rd_bit_ff <= fb_mem[rd_addr];
      end
   end

endmodule

@@ tb/sv/rect_fill_draw_device_test.sv @@
// ----------------------------------------------------------------------------
// Rectangle fill draw device testbench
// Drives port writes and pixel reads into the device and checks every reply
// word against a predictor kept in step with each accepted word or a typed
// directed row's given reply. Directed words come first, then random draws
// under three palettes, and last a sticky-fault run that keeps going.
// ----------------------------------------------------------------------------
module rect_fill_draw_device_test;

   localparam int SCREEN_W   = 64;
   localparam int SCREEN_H   = 64;
   localparam int PIXELS     = SCREEN_W * SCREEN_H;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic        command;
      logic [7:0]  port;
      logic [7:0]  value;
      logic [11:0] pixel_index;
   } dev_word_type;

   typedef struct packed {
      logic        fault;
      logic [31:0] frame_count;
      logic        handed_on;
      logic [31:0] pixel_color;
   } dev_reply_type;

   typedef struct {
      dev_word_type  word;
      bit            typed;
      dev_reply_type want;
   } stim_row_type;

   typedef enum int {FAULT_CODE, FAULT_COLOR, FAULT_BOUNDS, FAULT_EMPTY} fault_kind_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [31:0] csr_wdata;

   rfd_req_if req_ch ();
   rfd_rsp_if rsp_ch ();

   rect_fill_draw_device #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // device state as the predictor sees it
   logic [31:0] bg_argb;
   logic [31:0] ink_argb;
   logic [7:0]  cur_x, cur_y, cur_w, cur_h, cur_color;
   bit          screen_idx [PIXELS];
   logic        faulted;
   logic [31:0] frames;

   dev_reply_type pending_replies [$];
   stim_row_type  directed_rows [$];
   int            mismatch_count;
   int            words_sent;
   int            gap_pct;
   int            stall_pct;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // carry out one draw code on the predicted framebuffer
   function automatic void draw_into_screen(input logic [7:0] code);
      int x0, y0, w0, h0;
      if (code == rfd_pkg::DRAW_NOP || faulted)
         return;
      if (cur_color >= rfd_pkg::COLOR_COUNT) begin
         faulted = 1'b1;
         return;
      end
      if (code == rfd_pkg::DRAW_SCREEN) begin
         foreach (screen_idx[i])
            screen_idx[i] = cur_color[0];
      end else if (code == rfd_pkg::DRAW_RECT) begin
         x0 = int'(cur_x);
         y0 = int'(cur_y);
         w0 = int'(cur_w);
         h0 = int'(cur_h);
         if (x0 + w0 > SCREEN_W || y0 + h0 > SCREEN_H || w0 == 0 || h0 == 0) begin
            faulted = 1'b1;
            return;
         end
         for (int row = y0; row < y0 + h0; row++)
            for (int col = x0; col < x0 + w0; col++)
               screen_idx[row * SCREEN_W + col] = cur_color[0];
         frames++;
      end else begin
         faulted = 1'b1;
      end
   endfunction

   // advance the predicted state by one word and return its reply
   function automatic dev_reply_type apply_word(input dev_word_type w);
      dev_reply_type r;
      r = '0;
      if (w.command == rfd_pkg::CMD_WRITE) begin
         case (w.port)
            rfd_pkg::PORT_X:     cur_x = w.value;
            rfd_pkg::PORT_Y:     cur_y = w.value;
            rfd_pkg::PORT_W:     cur_w = w.value;
            rfd_pkg::PORT_H:     cur_h = w.value;
            rfd_pkg::PORT_COLOR: cur_color = w.value;
            default: ;
         endcase
         if (w.port == rfd_pkg::PORT_DRAW)
            draw_into_screen(w.value);
         else
            r.handed_on = 1'b1;
      end else if (int'(w.pixel_index) < PIXELS) begin
         r.pixel_color = screen_idx[w.pixel_index] ? ink_argb : bg_argb;
      end
      r.fault = faulted;
      r.frame_count = frames;
      return r;
   endfunction

   // offer one word, hold it until accepted, then queue its reply
   task automatic send_word(input dev_word_type w, input bit typed,
                            input dev_reply_type want);
      dev_reply_type predicted;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= w.command;
      req_ch.port        <= w.port;
      req_ch.value       <= w.value;
      req_ch.pixel_index <= w.pixel_index;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      predicted = apply_word(w);
      pending_replies.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   task automatic put(input logic [7:0] port, input logic [7:0] value);
      dev_word_type w;
      w.command = rfd_pkg::CMD_WRITE;
      w.port = port;
      w.value = value;
      w.pixel_index = 12'($urandom_range(0, 4095));
      send_word(w, 1'b0, '0);
   endtask

   task automatic peek(input logic [11:0] pix);
      dev_word_type w;
      w.command = rfd_pkg::CMD_READ;
      w.port = 8'($urandom_range(0, 255));
      w.value = 8'($urandom_range(0, 255));
      w.pixel_index = pix;
      send_word(w, 1'b0, '0);
   endtask

   function automatic void add_row(input logic cmd, input logic [7:0] port,
                                   input logic [7:0] value, input logic [11:0] pix,
                                   input bit typed, input logic handed,
                                   input logic [31:0] color);
      stim_row_type r;
      r.word.command = cmd;
      r.word.port = port;
      r.word.value = value;
      r.word.pixel_index = pix;
      r.typed = typed;
      r.want = '0;
      r.want.handed_on = handed;
      r.want.pixel_color = color;
      directed_rows.push_back(r);
   endfunction

   // drop valid, wait out every pending reply, then let the clock run on idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write both palette registers on back-to-back cycles
   task automatic load_palette(input logic [31:0] bg, input logic [31:0] ink);
      csr_wr_en <= 1'b1;
      csr_index <= rfd_pkg::CFG_BACKGROUND;
      csr_wdata <= bg;
      @(posedge clock);
      csr_index <= rfd_pkg::CFG_INK;
      csr_wdata <= ink;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bg_argb = bg;
      ink_argb = ink;
   endtask

   // mostly small spans, now and then up to the screen edge
   function automatic int pick_span(input int start);
      int room;
      room = SCREEN_W - start;
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(1, room);
      return $urandom_range(1, (room < 6) ? room : 6);
   endfunction

   // full parameter set, a draw, then a read inside the drawn area
   task automatic draw_sequence();
      int x0, y0, w0, h0;
      x0 = $urandom_range(0, SCREEN_W - 1);
      y0 = $urandom_range(0, SCREEN_H - 1);
      w0 = pick_span(x0);
      h0 = pick_span(y0);
      put(rfd_pkg::PORT_X, 8'(x0));
      put(rfd_pkg::PORT_Y, 8'(y0));
      put(rfd_pkg::PORT_W, 8'(w0));
      put(rfd_pkg::PORT_H, 8'(h0));
      put(rfd_pkg::PORT_COLOR, 8'($urandom_range(0, 1)));
      if ($urandom_range(0, 11) == 0)
         put(rfd_pkg::PORT_DRAW, rfd_pkg::DRAW_SCREEN);
      else
         put(rfd_pkg::PORT_DRAW, rfd_pkg::DRAW_RECT);
      peek(12'((y0 + $urandom_range(0, h0 - 1)) * SCREEN_W + x0
               + $urandom_range(0, w0 - 1)));
   endtask

   // random words that never trip the fault
   task automatic send_random(input int count);
      int target;
      logic [7:0] p;
      target = words_sent + count;
      while (words_sent < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: draw_sequence();
            6: peek(12'($urandom_range(0, 4095)));
            7: begin
               do p = 8'($urandom_range(0, 255)); while (p == rfd_pkg::PORT_DRAW);
               put(p, 8'($urandom_range(0, 255)));
            end
            8: put(rfd_pkg::PORT_DRAW, rfd_pkg::DRAW_NOP);
            default: begin
               // partial parameter set with no draw behind it
               repeat ($urandom_range(1, 4))
                  put(8'($urandom_range(rfd_pkg::PORT_X, rfd_pkg::PORT_COLOR)),
                      8'($urandom_range(0, 255)));
            end
         endcase
      end
   endtask

   // trip the sticky fault one way, then keep hitting the device
   task automatic break_device();
      fault_kind_type kind;
      int x0, w0;
      kind = fault_kind_type'($urandom_range(0, 3));
      put(rfd_pkg::PORT_COLOR, 8'($urandom_range(0, 1)));
      put(rfd_pkg::PORT_X, 8'd0);
      put(rfd_pkg::PORT_Y, 8'd0);
      put(rfd_pkg::PORT_W, 8'd1);
      put(rfd_pkg::PORT_H, 8'd1);
      case (kind)
         FAULT_CODE: put(rfd_pkg::PORT_DRAW, 8'($urandom_range(3, 255)));
         FAULT_COLOR: begin
            put(rfd_pkg::PORT_COLOR, 8'($urandom_range(2, 255)));
            put(rfd_pkg::PORT_DRAW,
                8'($urandom_range(rfd_pkg::DRAW_SCREEN, rfd_pkg::DRAW_RECT)));
         end
         FAULT_BOUNDS: begin
            x0 = $urandom_range(0, 255);
            w0 = $urandom_range(255, (x0 >= SCREEN_W) ? 0 : SCREEN_W + 1 - x0);
            if ($urandom_range(0, 1) == 0) begin
               put(rfd_pkg::PORT_X, 8'(x0));
               put(rfd_pkg::PORT_W, 8'(w0));
            end else begin
               put(rfd_pkg::PORT_Y, 8'(x0));
               put(rfd_pkg::PORT_H, 8'(w0));
            end
            put(rfd_pkg::PORT_DRAW, rfd_pkg::DRAW_RECT);
         end
         default: begin
            if ($urandom_range(0, 1) == 0)
               put(rfd_pkg::PORT_W, 8'd0);
            else
               put(rfd_pkg::PORT_H, 8'd0);
            put(rfd_pkg::PORT_DRAW, rfd_pkg::DRAW_RECT);
         end
      endcase
      repeat (10) begin
         case ($urandom_range(0, 2))
            0: peek(12'($urandom_range(0, 4095)));
            1: put(rfd_pkg::PORT_DRAW, 8'($urandom_range(0, 255)));
            default: put(8'($urandom_range(rfd_pkg::PORT_X, rfd_pkg::PORT_COLOR)),
                         8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // reply side: stall in bursts and check each accepted word
   initial begin
      int stall_left;
      dev_reply_type want;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
               flag_mismatch("reply word with nothing pending");
            end else begin
               want = pending_replies.pop_front();
               if (rsp_ch.fault !== want.fault)
                  flag_mismatch($sformatf("fault %0b, predicted %0b",
                                          rsp_ch.fault, want.fault));
               if (rsp_ch.frame_count !== want.frame_count)
                  flag_mismatch($sformatf("frame_count %0d, predicted %0d",
                                          rsp_ch.frame_count, want.frame_count));
               if (rsp_ch.handed_on !== want.handed_on)
                  flag_mismatch($sformatf("handed_on %0b, predicted %0b",
                                          rsp_ch.handed_on, want.handed_on));
               if (rsp_ch.pixel_color !== want.pixel_color)
                  flag_mismatch($sformatf("pixel_color %08h, predicted %08h",
                                          rsp_ch.pixel_color, want.pixel_color));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = int'($urandom_range(1, 7)) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // end the run when no word moves on either side for too long
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= IDLE_LIMIT) begin
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   // stimulus
   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.command <= rfd_pkg::CMD_WRITE;
      req_ch.port <= 8'h00;
      req_ch.value <= 8'h00;
      req_ch.pixel_index <= 12'h000;
      csr_wr_en <= 1'b0;
      csr_index <= rfd_pkg::CFG_BACKGROUND;
      csr_wdata <= 32'h0;

      mismatch_count = 0;
      words_sent = 0;
      gap_pct = 25;
      stall_pct = 25;
      bg_argb = rfd_pkg::BACKGROUND_RESET;
      ink_argb = rfd_pkg::INK_RESET;
      {cur_x, cur_y, cur_w, cur_h, cur_color} = '0;
      foreach (screen_idx[i])
         screen_idx[i] = 1'b0;
      faulted = 1'b0;
      frames = 32'd0;

      // blank screen reads background; port and value are ignored on reads
      add_row(rfd_pkg::CMD_READ, rfd_pkg::PORT_DRAW, rfd_pkg::DRAW_SCREEN, 12'h000,
              1'b1, 1'b0, rfd_pkg::BACKGROUND_RESET);
      add_row(rfd_pkg::CMD_READ, 8'hff, 8'hff, 12'hfff,
              1'b1, 1'b0, rfd_pkg::BACKGROUND_RESET);
      // ports outside the device are handed on
      add_row(rfd_pkg::CMD_WRITE, 8'h00, 8'hff, 12'hfff, 1'b1, 1'b1, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, 8'hff, 8'h00, 12'h000, 1'b1, 1'b1, 32'h0);
      // draw code zero leaves everything alone
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_DRAW, rfd_pkg::DRAW_NOP, 12'h000,
              1'b1, 1'b0, 32'h0);
      // whole screen in ink; a screen fill does not count a frame
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_COLOR, 8'd1, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_DRAW, rfd_pkg::DRAW_SCREEN, 12'h000,
              1'b1, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_READ, 8'h00, 8'h00, 12'h000, 1'b1, 1'b0, rfd_pkg::INK_RESET);
      add_row(rfd_pkg::CMD_READ, 8'h00, 8'h00, 12'hfff, 1'b1, 1'b0, rfd_pkg::INK_RESET);
      // largest rectangle, back to background
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_COLOR, 8'd0, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_X, 8'd0, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_Y, 8'd0, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_W, 8'd64, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_H, 8'd64, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_DRAW, rfd_pkg::DRAW_RECT, 12'h000,
              1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_READ, 8'h00, 8'h00, 12'd2048, 1'b0, 1'b0, 32'h0);
      // single ink pixel in the far corner, right at the bounds
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_X, 8'd63, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_Y, 8'd63, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_W, 8'd1, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_H, 8'd1, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_COLOR, 8'd1, 12'h000, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_WRITE, rfd_pkg::PORT_DRAW, rfd_pkg::DRAW_RECT, 12'h000,
              1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_READ, 8'h00, 8'h00, 12'hfff, 1'b0, 1'b0, 32'h0);
      add_row(rfd_pkg::CMD_READ, 8'h00, 8'h00, 12'hffe, 1'b0, 1'b0, 32'h0);

      // hold reset, then walk the directed table
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      settle();

      // palette extremes recolor what is already drawn
      load_palette(32'h0000_0000, 32'hffff_ffff);
      send_random(32);
      settle();

      gap_pct = 50;
      stall_pct = 50;
      load_palette(32'hffff_ffff, 32'h0000_0000);
      send_random(32);
      settle();

      // no idling from here to the end
      gap_pct = 0;
      stall_pct = 0;
      load_palette($urandom, $urandom);
      send_random(28);
      break_device();
      settle();

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ rect_fill_draw_device.f @@
+incdir+rtl/core
rtl/core/rfd_pkg.sv
rtl/core/rfd_req_if.sv
rtl/core/rfd_rsp_if.sv
rtl/core/rfd_queue.sv
rtl/core/rfd_front.sv
rtl/core/rfd_back.sv
rtl/core/rect_fill_draw_device.sv
tb/sv/rect_fill_draw_device_test.sv
